// ----- src/pibr_pkg.sv -----
// Shared types, codes and defaults for the pulse-interval byte receiver.
package pibr_pkg;

    // Default queue depth for received bytes
    localparam int FIFO_DEPTH_DEF = 16;

    // Commands carried by an input item
    localparam logic [1:0] CMD_EDGE       = 2'd0;
    localparam logic [1:0] CMD_FULL_RESET = 2'd1;
    localparam logic [1:0] CMD_SOFT_RESET = 2'd2;
    localparam logic [1:0] CMD_READ       = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAP_MIN  = 3'd0;
    localparam logic [2:0] CFG_ZERO_MAX = 3'd1;
    localparam logic [2:0] CFG_ONE_MIN  = 3'd2;
    localparam logic [2:0] CFG_GAP_MAX  = 3'd3;
    localparam logic [2:0] CFG_HDR_A    = 3'd4;
    localparam logic [2:0] CFG_HDR_B    = 3'd5;
    localparam logic [2:0] CFG_HDR_C    = 3'd6;

    // Configuration reset values
    localparam logic [15:0] GAP_MIN_RST  = 16'd350;
    localparam logic [15:0] ZERO_MAX_RST = 16'd450;
    localparam logic [15:0] ONE_MIN_RST  = 16'd700;
    localparam logic [15:0] GAP_MAX_RST  = 16'd1000;

    // Link states
    localparam logic [2:0] LINK_IDLE = 3'd0;
    localparam logic [2:0] LINK_ID1  = 3'd1;
    localparam logic [2:0] LINK_ID2  = 3'd2;
    localparam logic [2:0] LINK_ID3  = 3'd3;
    localparam logic [2:0] LINK_TX   = 3'd4;

    // Bit phase: awaiting a bit gap, or the next edge is a separator
    localparam logic [1:0] PH_BIT     = 2'd0;
    localparam logic [1:0] PH_SEP_ZRO = 2'd1;
    localparam logic [1:0] PH_SEP_ONE = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] edge_time_us;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [2:0] link_state;
        logic       cart_enable;
    } t_out_item;

    // Result of an accepted item, waiting for its read data from the store
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [2:0] link_state;
        logic       cart_enable;
    } t_pend;

endpackage

// ----- src/pibr_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
interface pibr_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/pibr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pibr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/pibr_core.sv -----
// Edge decoding, header match, byte queue control and configuration registers.
module pibr_core
    import pibr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic        i_pend_take,
    output t_pend       o_pend,
    output logic [7:0]  o_rdata
);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // Configuration
    logic [15:0] r_gap_min, r_zero_max, r_one_min, r_gap_max;
    logic [7:0]  r_hdr_a, r_hdr_b, r_hdr_c;

    // Decoder state
    logic [31:0]   r_last, n_last;
    logic [1:0]    r_phase, n_phase;
    logic [2:0]    r_mode, n_mode;
    logic [7:0]    r_shift, n_shift;
    logic [7:0]    r_pos, n_pos;
    logic          r_enable, n_enable;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    t_pend         r_pend;

    logic [31:0] gap;
    logic        gap_ok, is_zero, is_one;
    logic [7:0]  bit_shift, bit_pos;
    logic        push, pop, hit;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_min  <= GAP_MIN_RST;
            r_zero_max <= ZERO_MAX_RST;
            r_one_min  <= ONE_MIN_RST;
            r_gap_max  <= GAP_MAX_RST;
            r_hdr_a    <= '0;
            r_hdr_b    <= '0;
            r_hdr_c    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAP_MIN:  r_gap_min  <= i_cfg_data;
                CFG_ZERO_MAX: r_zero_max <= i_cfg_data;
                CFG_ONE_MIN:  r_one_min  <= i_cfg_data;
                CFG_GAP_MAX:  r_gap_max  <= i_cfg_data;
                CFG_HDR_A:    r_hdr_a    <= i_cfg_data[7:0];
                CFG_HDR_B:    r_hdr_b    <= i_cfg_data[7:0];
                CFG_HDR_C:    r_hdr_c    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Gap classification
    assign gap     = i_item.edge_time_us - r_last;
    assign gap_ok  = (gap >= {16'd0, r_gap_min}) && (gap <= {16'd0, r_gap_max});
    assign is_zero = gap_ok && (gap < {16'd0, r_zero_max});
    assign is_one  = gap_ok && !is_zero && (gap > {16'd0, r_one_min});

    assign bit_shift = is_one ? (r_shift | r_pos) : r_shift;
    assign bit_pos   = {r_pos[6:0], 1'b0};

    // Next state for one item
    always_comb begin
        n_last   = r_last;
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_shift  = r_shift;
        n_pos    = r_pos;
        n_enable = r_enable;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        push     = 1'b0;
        pop      = 1'b0;
        hit      = 1'b0;
        unique case (i_item.command)
            CMD_EDGE: begin
                n_last = i_item.edge_time_us;
                if (r_phase != PH_BIT) begin
                    n_phase = PH_BIT;
                end else if (is_zero || is_one) begin
                    n_phase = is_one ? PH_SEP_ONE : PH_SEP_ZRO;
                    n_shift = bit_shift;
                    n_pos   = bit_pos;
                    // Last bit of the byte
                    if (r_pos[7]) begin
                        n_shift = '0;
                        n_pos   = 8'd1;
                        unique case (r_mode)
                            LINK_IDLE: if (bit_shift == r_hdr_a) n_mode = LINK_ID1;
                            LINK_ID1:  if (bit_shift == r_hdr_b) n_mode = LINK_ID2;
                            LINK_ID2:  if (bit_shift == r_hdr_c) n_mode = LINK_ID3;
                            LINK_ID3: begin
                                push     = 1'b1;
                                n_mode   = LINK_TX;
                                n_enable = 1'b1;
                            end
                            LINK_TX:   push = 1'b1;
                            default: ;
                        endcase
                    end
                end else begin
                    n_shift = '0;
                    n_pos   = 8'd1;
                end
            end
            CMD_FULL_RESET, CMD_SOFT_RESET: begin
                n_phase = PH_BIT;
                n_pos   = 8'd1;
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                if (i_item.command == CMD_FULL_RESET) begin
                    n_mode = LINK_IDLE;
                end
            end
            CMD_READ: begin
                if (r_count != '0) begin
                    hit     = 1'b1;
                    pop     = 1'b1;
                    n_head  = (r_head == AW'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            default: ;
        endcase
        // Drop the byte when the queue is full
        if (push) begin
            if (r_count == CW'(FIFO_DEPTH)) begin
                push = 1'b0;
            end else begin
                n_tail  = (r_tail == AW'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                n_count = r_count + 1'b1;
            end
        end
    end

    // State registers; result fields of the accepted item, read data follows from the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= '0;
            r_phase      <= PH_BIT;
            r_mode       <= LINK_IDLE;
            r_shift      <= '0;
            r_pos        <= 8'd1;
            r_enable     <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_pend.valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_last             <= n_last;
                r_phase            <= n_phase;
                r_mode             <= n_mode;
                r_shift            <= n_shift;
                r_pos              <= n_pos;
                r_enable           <= n_enable;
                r_head             <= n_head;
                r_tail             <= n_tail;
                r_count            <= n_count;
                r_pend.hit         <= hit;
                r_pend.link_state  <= n_mode;
                r_pend.cart_enable <= n_enable;
            end
            if (i_accept) begin
                r_pend.valid <= 1'b1;
            end else if (i_pend_take) begin
                r_pend.valid <= 1'b0;
            end
        end
    end

    pibr_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_accept && push),
        .i_waddr (r_tail),
        .i_wdata (bit_shift),
        .i_re    (i_accept && pop),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    assign o_pend = r_pend;
endmodule

// ----- src/pibr_out_queue.sv -----
// Two-entry result queue that decouples the decoder from output back-pressure.
module pibr_out_queue
    import pibr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_pend        i_pend,
    input  logic [7:0]   i_rdata,
    output logic         o_take,
    output logic         o_full,
    pibr_stream_if.source o_out
);
    t_out_item r_q0, r_q1;
    logic [1:0] r_occ;
    t_out_item  item;
    logic       pop, push;

    // Assemble the result once the store data is in
    always_comb begin
        item.read_data   = i_pend.hit ? i_rdata : 8'd0;
        item.read_valid  = i_pend.hit;
        item.link_state  = i_pend.link_state;
        item.cart_enable = i_pend.cart_enable;
    end

    assign pop    = (r_occ != 2'd0) && o_out.ready;
    assign push   = i_pend.valid && ((r_occ != 2'd2) || pop);
    assign o_take = push;
    assign o_full = (r_occ == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   r_occ <= r_occ + 2'd1;
                2'b01:   r_occ <= r_occ - 2'd1;
                default: ;
            endcase
        end
    end

    // Slot data
    always_ff @(posedge i_clk) begin
        unique case ({push, pop})
            2'b11: begin
                if (r_occ == 2'd1) begin
                    r_q0 <= item;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= item;
                end
            end
            2'b10: begin
                if (r_occ == 2'd0) begin
                    r_q0 <= item;
                end else begin
                    r_q1 <= item;
                end
            end
            2'b01:   r_q0 <= r_q1;
            default: ;
        endcase
    end

    assign o_out.valid = (r_occ != 2'd0);
    assign o_out.data  = r_q0;
endmodule

// ----- src/pulse_interval_byte_receiver_unit.sv -----
// Top level of the pulse-interval byte receiver.
//
// Decodes bits from the spacing of timestamped falling edges (short gap = 0, long gap = 1,
// every edge after a bit edge is a separator), assembles bytes LSB first, matches a
// three-byte header and then queues received bytes in a FIFO_DEPTH-entry store that read
// commands drain. Every input item (edge, full reset, soft reset, read) gives exactly one
// result. An item is accepted in every cycle while input ready is high: the decoder state
// updates in the cycle of transfer, and the result passes through the registered read of
// the byte store and then the output queue. A two-entry output queue keeps input
// transfers going while a result waits; input ready drops only when both queue entries
// and the store-read stage are occupied. Configuration writes are taken at any time
// through the write port and should be made while the block is idle.
module pulse_interval_byte_receiver_unit
    import pibr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    pibr_stream_if.sink   i_in,
    pibr_stream_if.source o_out
);
    t_pend      pend;
    logic [7:0] rdata;
    logic       take, q_full, accept;

    // Hold input only when the read stage is waiting on a full queue
    assign i_in.ready = !(q_full && pend.valid);
    assign accept     = i_in.valid && i_in.ready;

    pibr_core #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in.data),
        .i_pend_take (take),
        .o_pend      (pend),
        .o_rdata     (rdata)
    );

    pibr_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pend  (pend),
        .i_rdata (rdata),
        .o_take  (take),
        .o_full  (q_full),
        .o_out   (o_out)
    );
endmodule

// ----- verif/tb_pulse_interval_byte_receiver_unit.sv -----
// Self-checking testbench for the pulse-interval byte receiver: table, framed traffic, FIFO drain.
module tb_pulse_interval_byte_receiver_unit;
    import pibr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam t_out_item RES_IDLE = '{read_data: 8'h00, read_valid: 1'b0,
                                       link_state: LINK_IDLE, cart_enable: 1'b0};

    // One row of the directed table; res is only used when typed is set
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] stamp;
        bit          typed;
        t_out_item   res;
    } dir_row_t;

    // Threshold and header setting of one phase of the random traffic
    typedef struct {
        logic [15:0] gap_min;
        logic [15:0] zero_max;
        logic [15:0] one_min;
        logic [15:0] gap_max;
        logic [7:0]  hdr_a;
        logic [7:0]  hdr_b;
        logic [7:0]  hdr_c;
        bit          hdr_rand;
        bit          fill_fifo;
        bit          quiet;
        int          budget;
    } cfg_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_data;

    pibr_stream_if #(.T_PAYLOAD(t_in_item))  in_ch ();
    pibr_stream_if #(.T_PAYLOAD(t_out_item)) out_ch ();

    pulse_interval_byte_receiver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Directed table, default thresholds (350/450/700/1000), link never leaves idle
    dir_row_t dir_rows [18] = '{
        '{CMD_READ,       32'h0000_0000, 1'b1, RES_IDLE},  // read on empty store
        '{CMD_EDGE,       32'h0000_0000, 1'b1, RES_IDLE},  // zero gap, invalid
        '{CMD_EDGE,       32'h0000_0190, 1'b0, RES_IDLE},  // gap 400: zero bit
        '{CMD_EDGE,       32'hFFFF_FFFF, 1'b0, RES_IDLE},  // separator
        '{CMD_EDGE,       32'h0000_015D, 1'b0, RES_IDLE},  // wrapped gap 350: zero bit
        '{CMD_EDGE,       32'h0000_03E8, 1'b0, RES_IDLE},  // separator
        '{CMD_EDGE,       32'h0000_07D0, 1'b0, RES_IDLE},  // gap 1000: one bit
        '{CMD_EDGE,       32'h0000_0834, 1'b0, RES_IDLE},  // separator
        '{CMD_EDGE,       32'h0000_09F6, 1'b1, RES_IDLE},  // gap 450: between bands
        '{CMD_EDGE,       32'h0000_0CB2, 1'b1, RES_IDLE},  // gap 700: between bands
        '{CMD_EDGE,       32'h0000_0F6F, 1'b0, RES_IDLE},  // gap 701: one bit
        '{CMD_SOFT_RESET, 32'hFFFF_FFFF, 1'b1, RES_IDLE},
        '{CMD_EDGE,       32'h0000_1358, 1'b1, RES_IDLE},  // gap 1001: too long
        '{CMD_EDGE,       32'h0000_14B5, 1'b1, RES_IDLE},  // gap 349: too short
        '{CMD_EDGE,       32'h0000_1645, 1'b0, RES_IDLE},  // gap 400: zero bit
        '{CMD_FULL_RESET, 32'hAAAA_AAAA, 1'b1, RES_IDLE},
        '{CMD_READ,       32'h5555_5555, 1'b1, RES_IDLE},
        '{CMD_EDGE,       32'h0000_0000, 1'b1, RES_IDLE}   // huge wrapped gap
    };

    cfg_row_t plan [7] = '{
        '{16'd350,   16'd450,   16'd700,   16'd1000,  8'hFF, 8'h00, 8'hA5, 1'b0, 1'b1, 1'b0, 1},
        '{16'd0,     16'd100,   16'd200,   16'd65535, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1},
        '{16'd1,     16'd2,     16'd3,     16'd5,     8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1},
        '{16'd65000, 16'd65100, 16'd65400, 16'd65535, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1},
        '{16'd0,     16'd0,     16'd0,     16'd0,     8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 0},
        '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 0},
        '{16'd350,   16'd450,   16'd700,   16'd1000,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 0}
    };

    // Receiver model: thresholds, header, bit decoder, link state and byte queue
    logic [15:0] thr_gap_min, thr_zero_max, thr_one_min, thr_gap_max;
    logic [7:0]  hdr_id [3];
    logic [31:0] prev_edge;
    logic [1:0]  sym_phase;
    logic [2:0]  link;
    logic [7:0]  acc_byte;
    logic [7:0]  acc_mask;
    logic [7:0]  rx_fifo [FIFO_DEPTH_DEF];
    int          rd_ptr, wr_ptr, fill;
    logic        cart_en;

    t_out_item   expected_results [$];
    t_out_item   got, want;

    logic [31:0] stim_t;
    bit          send_quiet, recv_quiet;
    int          stall_left, stall_pick;
    int          idle_cnt;
    int          n_items, n_checked, n_bytes, n_errors;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Short pauses mostly, occasionally a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Shift the decoded bit position; on a full byte, run header match / queueing
    function automatic void shift_in_bit();
        acc_mask = acc_mask << 1;
        if (acc_mask == 8'h00) begin
            case (link)
                LINK_IDLE: if (acc_byte == hdr_id[0]) link = LINK_ID1;
                LINK_ID1:  if (acc_byte == hdr_id[1]) link = LINK_ID2;
                LINK_ID2:  if (acc_byte == hdr_id[2]) link = LINK_ID3;
                default: begin
                    if (link == LINK_ID3) begin
                        link    = LINK_TX;
                        cart_en = 1'b1;
                    end
                    // full queue drops the byte
                    if (fill < FIFO_DEPTH_DEF) begin
                        rx_fifo[wr_ptr] = acc_byte;
                        wr_ptr = (wr_ptr + 1) % FIFO_DEPTH_DEF;
                        fill++;
                    end
                end
            endcase
            acc_byte = 8'h00;
            acc_mask = 8'h01;
        end
    endfunction

    // Advance the receiver model by one accepted item and return its result
    function automatic t_out_item rx_step(input logic [1:0] cmd, input logic [31:0] t);
        logic [31:0] gap;
        t_out_item   r;
        r = RES_IDLE;
        case (cmd)
            CMD_EDGE: begin
                gap       = t - prev_edge;
                prev_edge = t;
                if (sym_phase != PH_BIT) begin
                    sym_phase = PH_BIT;
                end else if (gap >= thr_gap_min && gap <= thr_gap_max && gap < thr_zero_max) begin
                    sym_phase = PH_SEP_ZRO;
                    shift_in_bit();
                end else if (gap >= thr_gap_min && gap <= thr_gap_max && gap > thr_one_min) begin
                    sym_phase = PH_SEP_ONE;
                    acc_byte  = acc_byte | acc_mask;
                    shift_in_bit();
                end else begin
                    acc_byte = 8'h00;
                    acc_mask = 8'h01;
                end
            end
            CMD_FULL_RESET, CMD_SOFT_RESET: begin
                if (cmd == CMD_FULL_RESET) link = LINK_IDLE;
                sym_phase = PH_BIT;
                acc_mask  = 8'h01;
                rd_ptr    = 0;
                wr_ptr    = 0;
                fill      = 0;
            end
            CMD_READ: begin
                if (fill > 0) begin
                    r.read_data  = rx_fifo[rd_ptr];
                    r.read_valid = 1'b1;
                    rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
                    fill--;
                end
            end
            default: ;
        endcase
        r.link_state  = link;
        r.cart_enable = cart_en;
        return r;
    endfunction

    // Drive one item and wait for its transfer; optional idle gap afterwards
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] t,
                             input bit typed = 1'b0, input t_out_item typed_res = RES_IDLE);
        t_out_item pred;
        int        pause;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{command: cmd, edge_time_us: t};
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        pred = rx_step(cmd, t);
        expected_results.push_back(typed ? typed_res : pred);
        n_items++;
        pause = send_quiet ? 0 : pick_pause();
        if (pause > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (pause - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_edge(input logic [31:0] gap);
        stim_t = stim_t + gap;
        send_item(CMD_EDGE, stim_t);
    endtask

    // Gap inside [lo, hi], biased toward the band edges
    function automatic logic [31:0] pick_range(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic logic [31:0] zero_gap();
        int lo, hi;
        lo = thr_gap_min;
        hi = int'(thr_zero_max) - 1;
        if (lo > hi) return $urandom();
        return pick_range(lo, hi);
    endfunction

    function automatic logic [31:0] one_gap();
        int lo, hi;
        lo = (int'(thr_one_min) + 1 > int'(thr_gap_min)) ? int'(thr_one_min) + 1
                                                         : int'(thr_gap_min);
        hi = thr_gap_max;
        if (lo > hi) return $urandom();
        return pick_range(lo, hi);
    endfunction

    // Eight bit edges, each followed by a separator edge; rare corrupted bits
    task automatic send_byte(input logic [7:0] b, input bit clean);
        for (int i = 0; i < 8; i++) begin
            if (!clean && $urandom_range(0, 49) == 0) send_edge($urandom());
            else send_edge(b[i] ? one_gap() : zero_gap());
            send_edge(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000));
        end
    endtask

    // Header (sometimes with a wrong byte) followed by payload bytes
    task automatic frame(input bit clean, input int n_payload, input bit reads);
        for (int k = 0; k < 3; k++) begin
            if (!clean && $urandom_range(0, 5) == 0)
                send_byte(hdr_id[k] ^ 8'($urandom_range(1, 255)), clean);
            else
                send_byte(hdr_id[k], clean);
        end
        for (int k = 0; k < n_payload; k++) begin
            send_byte(8'($urandom_range(0, 255)), clean);
            if (reads && $urandom_range(0, 9) < 4) send_item(CMD_READ, $urandom());
        end
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] d);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        case (idx)
            CFG_GAP_MIN:  thr_gap_min  = d;
            CFG_ZERO_MAX: thr_zero_max = d;
            CFG_ONE_MIN:  thr_one_min  = d;
            CFG_GAP_MAX:  thr_gap_max  = d;
            CFG_HDR_A:    hdr_id[0]    = d[7:0];
            CFG_HDR_B:    hdr_id[1]    = d[7:0];
            CFG_HDR_C:    hdr_id[2]    = d[7:0];
            default: ;
        endcase
    endtask

    // Write all registers of a phase while the block is idle
    task automatic load_cfg(input cfg_row_t c);
        drain();
        put_reg(CFG_GAP_MIN,  c.gap_min);
        put_reg(CFG_ZERO_MAX, c.zero_max);
        put_reg(CFG_ONE_MIN,  c.one_min);
        put_reg(CFG_GAP_MAX,  c.gap_max);
        put_reg(CFG_HDR_A, {8'($urandom()), c.hdr_rand ? 8'($urandom()) : c.hdr_a});
        put_reg(CFG_HDR_B, {8'($urandom()), c.hdr_rand ? 8'($urandom()) : c.hdr_b});
        put_reg(CFG_HDR_C, {8'($urandom()), c.hdr_rand ? 8'($urandom()) : c.hdr_c});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // One random chunk of traffic: mostly a frame, otherwise noise, reads, a reset or a drain
    task automatic run_episode();
        int r, n;
        r = $urandom_range(0, 99);
        n = $urandom_range(1, 6);
        if (r < 60) begin
            frame(1'b0, $urandom_range(1, 4), 1'b1);
        end else if (r < 72) begin
            repeat (n) send_edge($urandom_range(0, 1) ? $urandom()
                                                      : $urandom_range(0, 2 * thr_gap_max + 2));
        end else if (r < 84) begin
            repeat (n) send_item(CMD_READ, $urandom());
        end else if (r < 90) begin
            send_item(CMD_SOFT_RESET, $urandom());
        end else if (r < 94) begin
            send_item(CMD_FULL_RESET, $urandom());
        end else begin
            drain();
        end
    endtask

    // Result ready: random stalls, none in quiet phases
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (recv_quiet) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            stall_pick = pick_pause();
            out_ch.ready <= (stall_pick == 0);
            if (stall_pick > 0) stall_left = stall_pick - 1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (got.read_valid) n_bytes++;
                if (got.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %02h actual %02h",
                             $time, want.read_data, got.read_data);
                    n_errors++;
                end
                if (got.read_valid !== want.read_valid) begin
                    $display("%0t: read_valid expected %0b actual %0b",
                             $time, want.read_valid, got.read_valid);
                    n_errors++;
                end
                if (got.link_state !== want.link_state) begin
                    $display("%0t: link_state expected %0d actual %0d",
                             $time, want.link_state, got.link_state);
                    n_errors++;
                end
                if (got.cart_enable !== want.cart_enable) begin
                    $display("%0t: cart_enable expected %0b actual %0b",
                             $time, want.cart_enable, got.cart_enable);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cnt);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_GAP_MIN;
        cfg_data     = 16'h0000;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        send_quiet   = 1'b0;
        recv_quiet   = 1'b0;
        stall_left   = 0;
        idle_cnt     = 0;
        n_items      = 0;
        n_checked    = 0;
        n_bytes      = 0;
        n_errors     = 0;

        // model state after reset
        thr_gap_min  = GAP_MIN_RST;
        thr_zero_max = ZERO_MAX_RST;
        thr_one_min  = ONE_MIN_RST;
        thr_gap_max  = GAP_MAX_RST;
        hdr_id       = '{8'h00, 8'h00, 8'h00};
        prev_edge    = 32'h0;
        sym_phase    = PH_BIT;
        link         = LINK_IDLE;
        acc_byte     = 8'h00;
        acc_mask     = 8'h01;
        rd_ptr       = 0;
        wr_ptr       = 0;
        fill         = 0;
        cart_en      = 1'b0;
        foreach (rx_fifo[i]) rx_fifo[i] = 8'h00;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset thresholds
        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].res);
        stim_t = dir_rows[$size(dir_rows) - 1].stamp;

        // random phases, one per threshold/header setting
        foreach (plan[p]) begin
            load_cfg(plan[p]);
            send_quiet = plan[p].quiet;
            recv_quiet = plan[p].quiet;
            send_edge($urandom());
            if (plan[p].fill_fifo) begin
                // clean frame that overruns the queue, then drain and read it all back
                send_item(CMD_FULL_RESET, $urandom());
                frame(1'b1, FIFO_DEPTH_DEF + 2, 1'b0);
                drain();
                repeat (FIFO_DEPTH_DEF + 2) send_item(CMD_READ, $urandom());
            end
            begin : phase_body
                int phase_end;
                phase_end = n_items + plan[p].budget;
                while (n_items < phase_end) run_episode();
            end
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        drain();

        $display("Run: %0d input transfers over %0d threshold/header settings,", n_items,
                 $size(plan));
        $display("     %0d results checked, %0d queued bytes read back.", n_checked, n_bytes);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/pibr_pkg.sv
src/pibr_stream_if.sv
src/pibr_ram.sv
src/pibr_core.sv
src/pibr_out_queue.sv
src/pulse_interval_byte_receiver_unit.sv
verif/tb_pulse_interval_byte_receiver_unit.sv
